[rtl/assert_macros.svh]
// Assertion macro for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication check, disabled while reset is high
`define CHK_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`endif

[rtl/lcst_pkg.sv]
// Package for the leased code slot table: codes, states and command structs.
// No dependencies.
package lcst_pkg;
  localparam int SlotCountDefault = 16;
  localparam int IdW    = 64;
  localparam int LeaseW = 32;

  localparam logic [2:0] ACT_PREPARE = 3'd0;
  localparam logic [2:0] ACT_PUBLISH = 3'd1;
  localparam logic [2:0] ACT_ACQUIRE = 3'd2;
  localparam logic [2:0] ACT_EVICT   = 3'd3;
  localparam logic [2:0] ACT_RELEASE = 3'd4;
  localparam logic [2:0] ACT_COLLECT = 3'd5;

  localparam logic [2:0] S_OK            = 3'd0;
  localparam logic [2:0] S_BAD_ARG       = 3'd1;
  localparam logic [2:0] S_DUPLICATE     = 3'd2;
  localparam logic [2:0] S_FULL          = 3'd3;
  localparam logic [2:0] S_NOT_PREPARED  = 3'd4;
  localparam logic [2:0] S_STALE         = 3'd5;
  localparam logic [2:0] S_OVERFLOW      = 3'd6;
  localparam logic [2:0] S_INVALID_STATE = 3'd7;

  localparam logic [1:0] ST_FREE      = 2'd0;
  localparam logic [1:0] ST_PREPARED  = 2'd1;
  localparam logic [1:0] ST_PUBLISHED = 2'd2;
  localparam logic [1:0] ST_RETIRED   = 2'd3;

  typedef enum logic [2:0] {
    CS_IDLE, CS_SCAN, CS_FINISH, CS_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;    // capture input word, start
    logic scan;    // handle slot at scan index
    logic finish;  // single-slot commands and final result
    logic clr_idx;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_scan;
    logic scan_done;
  } dp_stat_t;
endpackage

[rtl/lcst_ctrl.sv]
// Controller for the leased code slot table: sequences load, scan, finish, output.
// Depends on lcst_pkg.
module lcst_ctrl import lcst_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_load
);
  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= CS_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    out_load = 1'b0;
    unique case (state)
      CS_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.clr_idx = 1'b1;
          state_next = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (stat.needs_scan && !stat.scan_done) begin
          cmd.scan = 1'b1;
        end else begin
          state_next = CS_FINISH;
        end
      end
      CS_FINISH: begin
        cmd.finish = 1'b1;
        state_next = CS_OUT;
      end
      CS_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end
endmodule

[rtl/lcst_dp.sv]
// Datapath for the leased code slot table: slot store, scan logic, result.
// Depends on lcst_pkg.
module lcst_dp import lcst_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [2:0]        action,
  input  logic [3:0]        slot_index,
  input  logic [IdW-1:0]    code_identity,
  input  logic [IdW-1:0]    signature_hash,
  input  logic [IdW-1:0]    layout_hash,
  input  logic [IdW-1:0]    abi_hash,
  output logic [2:0]        status,
  output logic [3:0]        result_slot,
  output logic [IdW-1:0]    result_identity,
  output logic [LeaseW-1:0] lease_after,
  output logic [4:0]        collected_count
);
  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  logic [1:0]        st   [SLOT_COUNT];
  logic [IdW-1:0]    sid  [SLOT_COUNT];
  logic [IdW-1:0]    ssig [SLOT_COUNT];
  logic [IdW-1:0]    slay [SLOT_COUNT];
  logic [IdW-1:0]    sabi [SLOT_COUNT];
  logic [LeaseW-1:0] slease [SLOT_COUNT];
  logic [CW-1:0]     used;
  logic              act_v;
  logic [IW-1:0]     act_s;

  logic [2:0]     a_act;
  logic [3:0]     a_slot;
  logic [IdW-1:0] a_id, a_sig, a_lay, a_abi;

  logic [CW-1:0] idx;
  logic          dup, have_free, found;
  logic [IW-1:0] free_i, found_i;
  logic [4:0]    ncol;

  logic [IW-1:0] si;
  logic [IW-1:0] hi;
  logic          h_in;
  logic [CW-1:0] idx_inc;

  // result of the command, from the state before finish
  logic [2:0]        fin_status;
  logic [3:0]        fin_slot;
  logic [IdW-1:0]    fin_id;
  logic [LeaseW-1:0] fin_lease;
  logic [4:0]        fin_col;

  assign si = idx[IW-1:0];
  assign idx_inc = idx + CW'(1);
  assign stat.scan_done = (idx == CW'(SLOT_COUNT)) ||
                          (a_act == ACT_EVICT && found);
  assign stat.needs_scan = (a_act == ACT_EVICT && a_id != '0) ||
                           (a_act == ACT_COLLECT) ||
                           (a_act == ACT_PREPARE && a_id != '0 && a_sig != '0 &&
                            a_lay != '0 && a_abi != '0);
  // handle slot, checked against the table size
  assign h_in = ({28'd0, a_slot} < 32'(SLOT_COUNT));
  assign hi = IW'(a_slot);

  always_comb begin
    fin_status = S_OK;
    fin_slot = '0;
    fin_id = '0;
    fin_lease = '0;
    fin_col = '0;
    case (a_act)
      ACT_PREPARE: begin
        if (!stat.needs_scan) fin_status = S_BAD_ARG;
        else if (dup) fin_status = S_DUPLICATE;
        else if (used >= CW'(SLOT_COUNT) || !have_free) fin_status = S_FULL;
        else begin
          fin_slot = 4'(free_i);
          fin_id = a_id;
        end
      end
      ACT_PUBLISH: begin
        if (!h_in || sid[hi] != a_id || st[hi] != ST_PREPARED)
          fin_status = S_NOT_PREPARED;
        else fin_lease = slease[hi];
      end
      ACT_ACQUIRE: begin
        if (!act_v || st[act_s] != ST_PUBLISHED) fin_status = S_STALE;
        else if (slease[act_s] == '1) begin
          fin_status = S_OVERFLOW;
          fin_lease = '1;
        end else begin
          fin_slot = 4'(act_s);
          fin_id = sid[act_s];
          fin_lease = slease[act_s] + LeaseW'(1);
        end
      end
      ACT_EVICT: begin
        if (a_id == '0) fin_status = S_BAD_ARG;
        else if (!found) fin_status = S_STALE;
        else fin_lease = slease[found_i];
      end
      ACT_RELEASE: begin
        if (!h_in || sid[hi] != a_id || st[hi] == ST_FREE) fin_status = S_STALE;
        else if (slease[hi] == '0) fin_status = S_INVALID_STATE;
        else fin_lease = slease[hi] - LeaseW'(1);
      end
      ACT_COLLECT: fin_col = ncol;
      default: fin_status = S_BAD_ARG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_act <= action; a_slot <= slot_index; a_id <= code_identity;
      a_sig <= signature_hash; a_lay <= layout_hash; a_abi <= abi_hash;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        st[i] <= ST_FREE; sid[i] <= '0; ssig[i] <= '0; slay[i] <= '0;
        sabi[i] <= '0; slease[i] <= '0;
      end
      used <= '0; act_v <= 1'b0; act_s <= '0;
      idx <= '0; dup <= 1'b0; have_free <= 1'b0; found <= 1'b0;
      free_i <= '0; found_i <= '0; ncol <= '0;
      status <= S_OK; result_slot <= '0; result_identity <= '0;
      lease_after <= '0; collected_count <= '0;
    end else begin
      if (cmd.clr_idx) begin
        idx <= '0; dup <= 1'b0; have_free <= 1'b0; found <= 1'b0; ncol <= '0;
      end
      if (cmd.scan) begin
        idx <= idx_inc;
        unique case (a_act)
          ACT_PREPARE: begin
            if (st[si] != ST_FREE && sid[si] == a_id) dup <= 1'b1;
            if (st[si] == ST_FREE && !have_free) begin
              have_free <= 1'b1; free_i <= si;
            end
          end
          ACT_EVICT: begin
            if (st[si] != ST_FREE && sid[si] == a_id) begin
              found <= 1'b1; found_i <= si;
            end
          end
          default: begin
            if (st[si] == ST_RETIRED && slease[si] == '0) begin
              st[si] <= ST_FREE; sid[si] <= '0; ssig[si] <= '0;
              slay[si] <= '0; sabi[si] <= '0;
              if (used != '0) used <= used - CW'(1);
              ncol <= ncol + 5'd1;
            end
          end
        endcase
      end
      if (cmd.finish) begin
        status <= fin_status; result_slot <= fin_slot; result_identity <= fin_id;
        lease_after <= fin_lease; collected_count <= fin_col;
        if (fin_status == S_OK) begin
          case (a_act)
            ACT_PREPARE: begin
              st[free_i] <= ST_PREPARED; sid[free_i] <= a_id;
              ssig[free_i] <= a_sig; slay[free_i] <= a_lay;
              sabi[free_i] <= a_abi; slease[free_i] <= '0;
              used <= used + CW'(1);
            end
            ACT_PUBLISH: begin
              if (act_v && act_s != hi && st[act_s] == ST_PUBLISHED)
                st[act_s] <= ST_RETIRED;
              st[hi] <= ST_PUBLISHED;
              act_v <= 1'b1; act_s <= hi;
            end
            ACT_ACQUIRE: slease[act_s] <= fin_lease;
            ACT_EVICT: begin
              if (st[found_i] != ST_RETIRED) begin
                st[found_i] <= ST_RETIRED;
                if (act_v && act_s == found_i) begin
                  act_v <= 1'b0; act_s <= '0;
                end
              end
            end
            ACT_RELEASE: slease[hi] <= fin_lease;
            default: ;
          endcase
        end
      end
    end
  end
endmodule

[rtl/leased_code_slot_table_core.sv]
// Top level of the leased code slot table: stream ports, controller, datapath.
// Depends on lcst_pkg, lcst_ctrl, lcst_dp.
//
// Table of SLOT_COUNT code slots (free, prepared, published, retired) with
// identity, three hashes and a lease count. One command word in gives one
// result word out. Publish, acquire, release and bad commands go from
// the scan state straight to finish and output; prepare and evict with
// valid arguments, and collect, walk the slot array one slot per cycle
// (evict stops at the first match). One command is in flight at a time;
// the result register holds until taken, and the next word is accepted
// once the previous result has been loaded into it. All slots clear at
// reset.
module leased_code_slot_table_core import lcst_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[2:0], slot_index[6:3], code_identity[70:7], signature_hash[134:71],
  // layout_hash[198:135], abi_hash[262:199], zero fill to 264
  input  logic [263:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[2:0], result_slot[6:3], result_identity[70:7], lease_after[102:71],
  // collected_count[107:103], zero fill to 112
  output logic [111:0] m_tdata
);
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic busy, out_load, in_fire, out_free;
  logic [2:0]        status;
  logic [3:0]        rslot;
  logic [IdW-1:0]    rid;
  logic [LeaseW-1:0] lease;
  logic [4:0]        ncol;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  lcst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(out_free),
    .stat(stat), .cmd(cmd), .busy(busy), .out_load(out_load)
  );

  lcst_dp #(.SLOT_COUNT(SLOT_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(s_tdata[2:0]), .slot_index(s_tdata[6:3]),
    .code_identity(s_tdata[70:7]), .signature_hash(s_tdata[134:71]),
    .layout_hash(s_tdata[198:135]), .abi_hash(s_tdata[262:199]),
    .status(status), .result_slot(rslot), .result_identity(rid),
    .lease_after(lease), .collected_count(ncol)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {4'd0, ncol, lease, rid, rslot, status};
  end
endmodule

[rtl/lcst_checker.sv]
// Port-level checker for leased_code_slot_table_core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module lcst_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata
);
  `CHK_IMPL(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result dropped")
  `CHK_IMPL(a_one, clk, rst, s_tvalid && s_tready |=> !s_tready, "second word taken in flight")
  `CHK_IMPL(a_pad, clk, rst, m_tvalid |-> m_tdata[111:108] == 4'd0, "fill bits set")
endmodule

bind leased_code_slot_table_core lcst_checker u_chk (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
